### src/mdn_pkg.sv
// mdn_pkg: shared types and constants for the batch median block.
// No dependencies; used by every module under src/.
package mdn_pkg;

  localparam int SAMPLE_W         = 12;
  localparam int DEF_SAMPLE_COUNT = 8;

  typedef logic [SAMPLE_W-1:0] sample_t;

  // Controls from the sequencer to the shared compare unit.
  typedef struct packed {
    logic load_cand;  // capture read data as the current candidate
    logic clr;        // clear the rank counters
    logic acc;        // compare read data against the candidate, count
  } cmp_ctrl_t;

  // Rank counts from the compare unit back to the sequencer.
  typedef struct packed {
    logic [6:0] lt_cnt;  // entries strictly below the candidate
    logic [6:0] le_cnt;  // entries at or below the candidate
  } cmp_stat_t;

endpackage

### src/mdn_sample_ram.sv
// mdn_sample_ram: batch buffer, one write port and one registered read port.
// Depends on mdn_pkg.
module mdn_sample_ram #(
  parameter int DEPTH = mdn_pkg::DEF_SAMPLE_COUNT,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic            clk,
  input  logic            wr_en,
  input  logic [AW-1:0]   wr_addr,
  input  mdn_pkg::sample_t wr_data,
  input  logic [AW-1:0]   rd_addr,
  output mdn_pkg::sample_t rd_data
);
  import mdn_pkg::*;

  sample_t mem [DEPTH];
  sample_t rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data_r <= mem[rd_addr];
  end

  assign rd_data = rd_data_r;

endmodule

### src/mdn_cmp_unit.sv
// mdn_cmp_unit: shared comparator with candidate register and rank counters.
// Depends on mdn_pkg.
module mdn_cmp_unit #(
  parameter int SAMPLE_COUNT = mdn_pkg::DEF_SAMPLE_COUNT,
  parameter int CNTW         = $clog2(SAMPLE_COUNT + 1)
) (
  input  logic               clk,
  input  mdn_pkg::cmp_ctrl_t ctrl,
  input  mdn_pkg::sample_t   rd_data,
  output mdn_pkg::sample_t   cand,
  output mdn_pkg::cmp_stat_t stat
);
  import mdn_pkg::*;

  sample_t         cand_r;
  logic [CNTW-1:0] lt_cnt_r, lt_cnt_nxt;
  logic [CNTW-1:0] le_cnt_r, le_cnt_nxt;
  logic            is_lt, is_le;

  // One magnitude compare serves both counters.
  assign is_lt = rd_data < cand_r;
  assign is_le = is_lt || (rd_data == cand_r);

  always_comb begin
    lt_cnt_nxt = lt_cnt_r;
    le_cnt_nxt = le_cnt_r;
    if (ctrl.clr) begin
      lt_cnt_nxt = '0;
      le_cnt_nxt = '0;
    end else if (ctrl.acc) begin
      lt_cnt_nxt = lt_cnt_r + CNTW'(is_lt);
      le_cnt_nxt = le_cnt_r + CNTW'(is_le);
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.load_cand) begin
      cand_r <= rd_data;
    end
    lt_cnt_r <= lt_cnt_nxt;
    le_cnt_r <= le_cnt_nxt;
  end

  assign cand        = cand_r;
  assign stat.lt_cnt = 7'(lt_cnt_r);
  assign stat.le_cnt = 7'(le_cnt_r);

endmodule

### src/mdn_seq.sv
// mdn_seq: sequencer for sample collection, rank selection and result output.
// Depends on mdn_pkg; drives mdn_sample_ram and mdn_cmp_unit.
module mdn_seq #(
  parameter int SAMPLE_COUNT = mdn_pkg::DEF_SAMPLE_COUNT,
  parameter int AW           = (SAMPLE_COUNT > 1) ? $clog2(SAMPLE_COUNT) : 1
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  output logic               out_valid,
  input  logic               out_ready,
  output mdn_pkg::sample_t   out_median,
  output logic               wr_en,
  output logic [AW-1:0]      wr_addr,
  output logic [AW-1:0]      rd_addr,
  output mdn_pkg::cmp_ctrl_t ctrl,
  input  mdn_pkg::sample_t   cand,
  input  mdn_pkg::cmp_stat_t stat
);
  import mdn_pkg::*;

  localparam logic [AW-1:0] LAST = AW'(SAMPLE_COUNT - 1);
  localparam logic [6:0]    KPOS = 7'(SAMPLE_COUNT / 2);

  typedef enum logic [2:0] {
    S_COLLECT, S_FETCH, S_CAND, S_SCAN, S_TAIL, S_CHECK
  } state_t;

  state_t        state_r, state_nxt;
  logic [AW-1:0] fill_r, fill_nxt;
  logic [AW-1:0] cand_idx_r, cand_idx_nxt;
  logic [AW-1:0] scan_idx_r, scan_idx_nxt;
  logic          out_valid_r, out_valid_nxt;
  sample_t       out_median_r, out_median_nxt;
  logic          in_xfer, hit;

  assign in_xfer = in_valid && in_ready;
  assign hit     = (stat.lt_cnt <= KPOS) && (stat.le_cnt > KPOS);

  assign in_ready   = (state_r == S_COLLECT);
  assign out_valid  = out_valid_r;
  assign out_median = out_median_r;
  assign wr_en      = in_xfer;
  assign wr_addr    = fill_r;
  assign rd_addr    = (state_r == S_FETCH) ? cand_idx_r : scan_idx_r;

  always_comb begin
    ctrl.load_cand = (state_r == S_CAND);
    ctrl.clr       = (state_r == S_CAND);
    // Read data arrives in the cycle after its address is issued.
    ctrl.acc       = ((state_r == S_SCAN) && (scan_idx_r != '0)) || (state_r == S_TAIL);
  end

  always_comb begin
    state_nxt      = state_r;
    fill_nxt       = fill_r;
    cand_idx_nxt   = cand_idx_r;
    scan_idx_nxt   = scan_idx_r;
    out_valid_nxt  = out_valid_r && !out_ready;
    out_median_nxt = out_median_r;
    unique case (state_r)
      S_COLLECT: begin
        if (in_xfer) begin
          if (fill_r == LAST) begin
            fill_nxt     = '0;
            cand_idx_nxt = '0;
            state_nxt    = S_FETCH;
          end else begin
            fill_nxt = fill_r + AW'(1);
          end
        end
      end
      S_FETCH: state_nxt = S_CAND;
      S_CAND: begin
        scan_idx_nxt = '0;
        state_nxt    = S_SCAN;
      end
      S_SCAN: begin
        if (scan_idx_r == LAST) begin
          state_nxt = S_TAIL;
        end else begin
          scan_idx_nxt = scan_idx_r + AW'(1);
        end
      end
      S_TAIL: state_nxt = S_CHECK;
      S_CHECK: begin
        if (hit) begin
          // Hold until the result register is free.
          if (!out_valid_r || out_ready) begin
            out_valid_nxt  = 1'b1;
            out_median_nxt = cand;
            state_nxt      = S_COLLECT;
          end
        end else begin
          cand_idx_nxt = cand_idx_r + AW'(1);
          state_nxt    = S_FETCH;
        end
      end
      default: state_nxt = S_COLLECT;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_COLLECT;
      fill_r      <= '0;
      cand_idx_r  <= '0;
      scan_idx_r  <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      fill_r      <= fill_nxt;
      cand_idx_r  <= cand_idx_nxt;
      scan_idx_r  <= scan_idx_nxt;
      out_valid_r <= out_valid_nxt;
    end
    out_median_r <= out_median_nxt;
  end

  // The batch always holds the element of rank N/2, so the scan never runs past it.
  a_cand_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    cand_idx_r <= LAST)
    else $error("candidate index past end of batch");

  a_fill_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    fill_r <= LAST)
    else $error("fill count past end of batch");

  a_last_starts_sort: assert property (@(posedge clk) disable iff (!rst_n)
    (in_xfer && fill_r == LAST) |=> (state_r == S_FETCH && cand_idx_r == '0))
    else $error("completed batch did not start selection");

  a_result_has_rank: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(hit && state_r == S_CHECK))
    else $error("result issued without rank match");

endmodule

### src/median_of_n_samples.sv
// median_of_n_samples: top level of the batch median block.
// Depends on mdn_pkg, mdn_sample_ram, mdn_cmp_unit and mdn_seq.
//
// Collects SAMPLE_COUNT 12-bit converter samples per batch and, once the
// last sample of a batch is taken, returns one transaction holding the batch
// element of sorted rank SAMPLE_COUNT/2 (the upper median for even counts).
// Partial batches return nothing, and the next sample after a full batch
// starts a fresh one. Samples of a batch are accepted one per cycle. After
// the last one, a single comparator ranks each stored entry in turn against
// the whole batch, streaming the buffer through its one read port: every
// candidate is fetched, loaded, scanned against every entry and checked, and
// the search stops at the first entry whose rank covers SAMPLE_COUNT/2.
// in_ready is low during selection. The result sits in an output register,
// so collection of the next batch continues while it waits to be taken;
// selection only stalls if the previous result is still held.
module median_of_n_samples #(
  parameter int SAMPLE_COUNT = mdn_pkg::DEF_SAMPLE_COUNT
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_ready,
  input  mdn_pkg::sample_t in_sample,
  output logic             out_valid,
  input  logic             out_ready,
  output mdn_pkg::sample_t out_median
);
  import mdn_pkg::*;

  localparam int AW = (SAMPLE_COUNT > 1) ? $clog2(SAMPLE_COUNT) : 1;

  logic          wr_en;
  logic [AW-1:0] wr_addr;
  logic [AW-1:0] rd_addr;
  sample_t       rd_data;
  sample_t       cand;
  cmp_ctrl_t     ctrl;
  cmp_stat_t     stat;

  // Batch buffer: written while collecting, streamed out during selection.
  mdn_sample_ram #(
    .DEPTH (SAMPLE_COUNT),
    .AW    (AW)
  ) u_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (in_sample),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  // Shared comparator: counts entries below and at the current candidate.
  mdn_cmp_unit #(
    .SAMPLE_COUNT (SAMPLE_COUNT)
  ) u_cmp (
    .clk     (clk),
    .ctrl    (ctrl),
    .rd_data (rd_data),
    .cand    (cand),
    .stat    (stat)
  );

  // Sequencer: fill count, candidate and scan indices, result register.
  mdn_seq #(
    .SAMPLE_COUNT (SAMPLE_COUNT),
    .AW           (AW)
  ) u_seq (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_median (out_median),
    .wr_en      (wr_en),
    .wr_addr    (wr_addr),
    .rd_addr    (rd_addr),
    .ctrl       (ctrl),
    .cand       (cand),
    .stat       (stat)
  );

endmodule

### tb/sv/median_of_n_samples_tb.sv
// median_of_n_samples_tb: self-checking testbench for the batch median block.
// Depends on mdn_pkg and median_of_n_samples; predicts each median from the
// samples it sees accepted and checks every returned transaction in order.
`timescale 1ns / 100ps

module median_of_n_samples_tb #(
  parameter int SAMPLE_COUNT = mdn_pkg::DEF_SAMPLE_COUNT
);
  import mdn_pkg::*;

  localparam int CLK_PERIOD    = 10;
  localparam int MEDIAN_RANK   = SAMPLE_COUNT / 2;
  localparam int RANDOM_ITEMS  = 1400;
  // Worst-case selection: every stored entry tried as a candidate.
  localparam int SELECT_CYCLES = SAMPLE_COUNT * (SAMPLE_COUNT + 4);
  localparam int HOLD_CYCLES   = 4 * (SAMPLE_COUNT + SELECT_CYCLES) + 50;
  localparam int MAX_REPORTS   = 10;
  // Slowest correct run: every sample waits the longest sender gap, every
  // batch the longest selection and receiver stall, plus the long hold-off.
  // Take that five times over.
  localparam longint LIMIT_CYCLES =
    5 * (6 * 1500 + (1500 / SAMPLE_COUNT + 1) * (SELECT_CYCLES + 6) + HOLD_CYCLES + 1000);

  typedef sample_t batch_t [SAMPLE_COUNT];

  // Shapes of random batches; clustered and flat batches force many ties.
  typedef enum int {
    BATCH_SPREAD,
    BATCH_CLUSTER,
    BATCH_FLAT,
    BATCH_RISING,
    BATCH_FALLING
  } batch_kind_t;

  logic    clk       = 1'b0;
  logic    rst_n;
  logic    in_valid;
  logic    in_ready;
  sample_t in_sample;
  logic    out_valid;
  logic    out_ready = 1'b0;
  sample_t out_median;

  // Predictor state: the batch being collected and the medians still owed.
  batch_t  batch_buf;
  int      batch_fill = 0;
  sample_t expected_medians[$];

  int mismatches = 0;

  // Idling controls, shared between the stimulus tasks and the receiver.
  bit tx_idle_on = 1'b1;
  bit rx_idle_on = 1'b1;
  int rx_wait    = 0;
  int rx_hold    = 0;

  median_of_n_samples #(
    .SAMPLE_COUNT(SAMPLE_COUNT)
  ) dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_sample (in_sample),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_median(out_median)
  );

  always begin
    #(CLK_PERIOD / 2) clk = 1'b1;
    #(CLK_PERIOD / 2) clk = 1'b0;
  end

  // Pick the entry whose sorted position covers the median rank: fewer than
  // MEDIAN_RANK+1 entries lie strictly below it, more than MEDIAN_RANK at or
  // below it. Ties resolve to the same value whichever copy is picked.
  function automatic sample_t rank_select(input batch_t b);
    int below;
    int at_or_below;
    for (int i = 0; i < SAMPLE_COUNT; i++) begin
      below       = 0;
      at_or_below = 0;
      for (int j = 0; j < SAMPLE_COUNT; j++) begin
        if (b[j] < b[i])  below++;
        if (b[j] <= b[i]) at_or_below++;
      end
      if (below <= MEDIAN_RANK && at_or_below > MEDIAN_RANK) return b[i];
    end
    return '0;
  endfunction

  // Check returned medians first, then log accepted samples. Keeping both in
  // one block fixes their order within the edge.
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      if (expected_medians.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS)
          $display("%0t: median %0d returned with no batch pending", $time, out_median);
      end else begin
        if (out_median !== expected_medians[0]) begin
          mismatches++;
          if (mismatches <= MAX_REPORTS)
            $display("%0t: median mismatch, expected %0d, actual %0d",
                     $time, expected_medians[0], out_median);
        end
        void'(expected_medians.pop_front());
      end
      // Draw the receiver's wait ahead of the next transaction.
      rx_wait = rx_idle_on ? $urandom_range(0, 5) : 0;
    end
    if (rst_n && in_valid && in_ready) begin
      batch_buf[batch_fill] = in_sample;
      if (batch_fill == SAMPLE_COUNT - 1) begin
        expected_medians.push_back(rank_select(batch_buf));
        batch_fill = 0;
      end else begin
        batch_fill++;
      end
    end
  end

  // Receiver: hold out_ready low for a requested long hold-off first, then
  // for the drawn per-transaction wait, otherwise keep it high.
  always @(negedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else if (rx_hold > 0) begin
      out_ready <= 1'b0;
      rx_hold--;
    end else if (rx_wait > 0) begin
      out_ready <= 1'b0;
      rx_wait--;
    end else begin
      out_ready <= 1'b1;
    end
  end

  // Offer one sample after a drawn gap and hold it until it is taken. Valid
  // is only lowered when a gap is drawn, so back-to-back transactions never
  // see valid dropped and raised in the same step.
  task automatic send_sample(input sample_t s);
    int gap;
    gap = tx_idle_on ? $urandom_range(0, 5) : 0;
    @(negedge clk);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid  <= 1'b1;
    in_sample <= s;
    do @(posedge clk); while (!in_ready);
  endtask

  // Extremes and ties: alternating zero and full scale (upper median picks
  // full scale for even batches), a falling walking one, then a walking zero.
  task automatic test_directed_batches();
    tx_idle_on = 1'b1;
    rx_idle_on = 1'b1;
    for (int i = 0; i < SAMPLE_COUNT; i++)
      send_sample((i % 2) ? sample_t'(12'hFFF) : sample_t'(12'h000));
    for (int i = 0; i < SAMPLE_COUNT; i++)
      send_sample(sample_t'(12'h800 >> (i % SAMPLE_W)));
    for (int i = 0; i < SAMPLE_COUNT; i++)
      send_sample(~sample_t'(12'h001 << (i % SAMPLE_W)));
  endtask

  // Hold the receiver off while the sender streams batches back to back:
  // one median parks in the output register, the next batch is collected,
  // and its selection must stall until the held median is taken.
  task automatic test_output_backpressure();
    tx_idle_on = 1'b0;
    rx_idle_on = 1'b0;
    rx_hold    = HOLD_CYCLES;
    for (int i = 0; i < 3 * SAMPLE_COUNT; i++)
      send_sample(sample_t'($urandom));
  endtask

  // Whole batches of random shape; idling switches on and off now and then
  // so some stretches run at full rate. A partial batch, possibly empty, closes the run.
  task automatic test_random_batches();
    batch_kind_t kind;
    sample_t     base;
    int          span;
    int          sent;
    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      if ($urandom_range(0, 7) == 0) begin
        tx_idle_on = 1'($urandom_range(0, 1));
        rx_idle_on = 1'($urandom_range(0, 1));
      end
      kind = batch_kind_t'($urandom_range(BATCH_SPREAD, BATCH_FALLING));
      base = sample_t'($urandom);
      span = $urandom_range(1, 64);
      for (int i = 0; i < SAMPLE_COUNT; i++) begin
        case (kind)
          BATCH_SPREAD:  send_sample(sample_t'($urandom));
          BATCH_CLUSTER: send_sample(base + sample_t'($urandom_range(0, span - 1)));
          BATCH_FLAT:    send_sample(base);
          BATCH_RISING:  send_sample(base + sample_t'(i * span));
          default:       send_sample(base - sample_t'(i * span));
        endcase
      end
      sent += SAMPLE_COUNT;
    end
    repeat ($urandom_range(0, SAMPLE_COUNT - 1)) send_sample(sample_t'($urandom));
  endtask

  initial begin
    rst_n     = 1'b0;
    in_valid  = 1'b0;
    in_sample = '0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    test_directed_batches();
    test_output_backpressure();
    test_random_batches();

    // Drop valid after the last transaction, drain, then let the block settle.
    @(negedge clk);
    in_valid <= 1'b0;
    while (expected_medians.size() != 0) @(posedge clk);
    repeat (SELECT_CYCLES + 20) @(posedge clk);

    if (mismatches == 0 && expected_medians.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      if (expected_medians.size() != 0)
        $display("%0d medians never returned", expected_medians.size());
      $display("CHECKS FAILED");
    end
    $finish;
  end

  initial begin
    #(LIMIT_CYCLES * CLK_PERIOD);
    $display("timeout after %0d cycles", LIMIT_CYCLES);
    $display("CHECKS FAILED");
    $finish;
  end

endmodule
